>>> sv/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg: shared types, constants and helpers of the leg inverse kinematics.
// Holds the configuration bundle, the foot position word, the result word,
// the CORDIC arctangent table and the saturation helper.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int POS_W  = 16;  // Q12.4 coordinates
  localparam int LEN_W  = 15;  // link lengths and offset
  localparam int ANG_W  = 16;  // Q2.13 angles
  localparam int ARG_W  = 49;  // CORDIC operand width
  localparam int Z_W    = 34;  // CORDIC angle accumulator, Q2.30
  localparam int MUL_W  = 34;  // multiplier operand width
  localparam int PROD_W = 68;  // multiplier product width
  localparam int ACC_W  = 66;  // solver accumulator width
  localparam int SQ_W   = 64;  // square root radicand width

  // Configuration register indexes.
  localparam logic [2:0] REG_UPPER_LEN   = 3'd0;
  localparam logic [2:0] REG_LOWER_LEN   = 3'd1;
  localparam logic [2:0] REG_HIP_OFFSET  = 3'd2;
  localparam logic [2:0] REG_HOME_XFRONT = 3'd3;
  localparam logic [2:0] REG_HOME_XBACK  = 3'd4;
  localparam logic [2:0] REG_HOME_Y      = 3'd5;
  localparam logic [2:0] REG_HOME_Z      = 3'd6;

  // Operation codes.
  localparam logic OP_MOVE   = 1'b0;
  localparam logic OP_ATTACH = 1'b1;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic        [LEN_W-1:0] upper_len;
    logic        [LEN_W-1:0] lower_len;
    logic        [LEN_W-1:0] hip_off;
    logic signed [POS_W-1:0] home_x_front;
    logic signed [POS_W-1:0] home_x_back;
    logic signed [POS_W-1:0] home_y;
    logic signed [POS_W-1:0] home_z;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] hip;
    logic signed [ANG_W-1:0] thigh;
    logic signed [ANG_W-1:0] knee;
    logic                    reachable;
    pos_t                    foot;
  } res_t;

  // Saturate an 18-bit sum to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      5'd31: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/lik_front.sv
// ----------------------------------------------------------------------------
// lik_front: input side of the leg solver.
// Accepts move and attach words, keeps the foot position and hands the new
// position of each word to the solver queue.
// ----------------------------------------------------------------------------
module lik_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 op,
  input  logic                 front_leg,
  input  logic signed [15:0]   delta_x,
  input  logic signed [15:0]   delta_y,
  input  logic signed [15:0]   delta_z,
  input  lik_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output lik_pkg::pos_t        q_data
);

  lik_pkg::pos_t foot;
  lik_pkg::pos_t foot_next;
  logic signed [17:0] sum_x, sum_y, sum_z;

  assign q_push = push && !q_full;

  // Saturating move sums.
  assign sum_x = {{2{foot.x[15]}}, foot.x} + {{2{delta_x[15]}}, delta_x};
  assign sum_y = {{2{foot.y[15]}}, foot.y} + {{2{delta_y[15]}}, delta_y};
  assign sum_z = {{2{foot.z[15]}}, foot.z} + {{2{delta_z[15]}}, delta_z};

  // New position: home point on attach, moved point otherwise.
  always_comb begin
    if (op == lik_pkg::OP_ATTACH) begin
      foot_next.x = front_leg ? cfg.home_x_front : cfg.home_x_back;
      foot_next.y = cfg.home_y;
      foot_next.z = cfg.home_z;
    end else begin
      foot_next.x = lik_pkg::sat16(sum_x);
      foot_next.y = lik_pkg::sat16(sum_y);
      foot_next.z = lik_pkg::sat16(sum_z);
    end
  end

  assign q_data = foot_next;

  // Foot position register.
  always_ff @(posedge clk) begin
    if (rst) begin
      foot <= '0;
    end else if (q_push) begin
      foot <= foot_next;
    end
  end

endmodule

>>> sv/lik_queue.sv
// ----------------------------------------------------------------------------
// lik_queue: two-entry queue of foot positions between front and solver.
// ----------------------------------------------------------------------------
module lik_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  lik_pkg::pos_t wr_data,
  input  logic          rd,
  output lik_pkg::pos_t rd_data,
  output logic          full,
  output logic          empty
);

  lik_pkg::pos_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/lik_isqrt.sv
// ----------------------------------------------------------------------------
// lik_isqrt: integer square root, one result bit per cycle.
// Floor square root of a 64-bit radicand.
// ----------------------------------------------------------------------------
module lik_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lik_pkg::SQ_W-1:0] value,
  output logic                     done,
  output logic [31:0]              root
);

  logic [lik_pkg::SQ_W-1:0] rem;
  logic [lik_pkg::SQ_W-1:0] r;
  logic [lik_pkg::SQ_W-1:0] b;
  logic [lik_pkg::SQ_W-1:0] trial;
  logic                     running;

  assign trial = r + b;
  assign root  = r[31:0];

  // One digit of the root per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= value;
        r       <= '0;
        b       <= {2'b01, {(lik_pkg::SQ_W-2){1'b0}}};
      end else if (running) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r   <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b == {{(lik_pkg::SQ_W-1){1'b0}}, 1'b1}) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/lik_cordic.sv
// ----------------------------------------------------------------------------
// lik_cordic: vectoring CORDIC arctangent unit.
// Pre-rotates a left half-plane vector, scales both operands down one bit
// a cycle below 2^30, then runs one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module lik_cordic #(
  parameter int ITERS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lik_pkg::ARG_W-1:0]    y_in,
  input  logic signed [lik_pkg::ARG_W-1:0]    x_in,
  output logic                                done,
  output logic signed [16:0]                  angle
);

  localparam int IW = $clog2(ITERS);
  localparam logic signed [lik_pkg::ARG_W-1:0] LIM =
    {{(lik_pkg::ARG_W-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [lik_pkg::Z_W-1:0] HALF_LSB =
    {{(lik_pkg::Z_W-17){1'b0}}, 1'b1, 16'b0};

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

  cstate_t                            state;
  logic signed [lik_pkg::ARG_W-1:0]   x, y, xs, ys;
  logic signed [lik_pkg::Z_W-1:0]     z, ent, z_step, z_round;
  logic [IW-1:0]                      i;

  // Shifted operands and table entry of the current step.
  assign xs      = x >>> i;
  assign ys      = y >>> i;
  assign ent     = $signed({4'b0, lik_pkg::atan_entry(5'(i))});
  assign z_step  = y[lik_pkg::ARG_W-1] ? (z - ent) : (z + ent);
  assign z_round = z_step + HALF_LSB;

  // Control and datapath of the rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            i <= '0;
            if (x_in == '0 && y_in == '0) begin
              angle <= '0;
              done  <= 1'b1;
            end else begin
              state <= C_NORM;
              if (x_in[lik_pkg::ARG_W-1]) begin
                if (!y_in[lik_pkg::ARG_W-1]) begin
                  x <= y_in;
                  y <= -x_in;
                  z <= lik_pkg::HALF_PI_Q30;
                end else begin
                  x <= -y_in;
                  y <= x_in;
                  z <= -lik_pkg::HALF_PI_Q30;
                end
              end else begin
                x <= x_in;
                y <= y_in;
                z <= '0;
              end
            end
          end
        end
        C_NORM: begin
          if (x >= LIM || y >= LIM || y <= -LIM) begin
            x <= x >>> 1;
            y <= y >>> 1;
          end else begin
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (!y[lik_pkg::ARG_W-1]) begin
            x <= x + ys;
            y <= y - xs;
          end else begin
            x <= x - ys;
            y <= y + xs;
          end
          z <= z_step;
          i <= i + 1'b1;
          if (i == IW'(ITERS - 1)) begin
            angle <= z_round[lik_pkg::Z_W-1:17];
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lik_solver.sv
// ----------------------------------------------------------------------------
// lik_solver: back end of the leg solver.
// Sequences one shared multiplier, the square root unit and the CORDIC
// unit to solve the three joint angles, and holds the result word.
// ----------------------------------------------------------------------------
module lik_solver #(
  parameter int ITERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  lik_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  lik_pkg::pos_t q_data,
  output logic          q_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output lik_pkg::res_t out_res
);

  typedef enum logic [4:0] {
    S_IDLE, S_YY, S_ZZ, S_DD, S_XX, S_L1, S_L2, S_LL, S_CHK,
    S_RZ_GO, S_RZ_WAIT, S_DEN2, S_NUM2, S_DIFF, S_S_WAIT,
    S_T1, S_T2, S_T3, S_T4, S_AT_GO, S_AT_WAIT, S_FIN, S_OUT
  } state_t;

  state_t                                state;
  lik_pkg::pos_t                         pos;
  logic signed [lik_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic signed [lik_pkg::PROD_W-1:0]     prod;
  logic signed [lik_pkg::ACC_W-1:0]      acc, acc_diff;
  logic signed [33:0]                    r2, num, anum_c;
  logic        [31:0]                    den, den_c;
  logic        [32:0]                    anum;
  logic        [15:0]                    rz;
  logic        [30:0]                    s;
  logic signed [lik_pkg::ARG_W-1:0]      ay, ax, cy, cx;
  logic        [2:0]                     k;
  logic signed [16:0]                    at [5];
  logic signed [lik_pkg::ANG_W-1:0]      last_hip, last_thigh, last_knee;
  logic                                  ok;
  logic                                  out_valid;
  logic                                  fail;
  logic                                  sq_start, sq_done;
  logic        [lik_pkg::SQ_W-1:0]       sq_value;
  logic        [31:0]                    sq_root;
  logic                                  cd_start, cd_done;
  logic signed [16:0]                    cd_angle;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_empty = !out_valid;
  assign acc_diff  = acc - prod[lik_pkg::ACC_W-1:0];

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_YY: begin
        mul_a = {{18{pos.y[15]}}, pos.y};
        mul_b = {{18{pos.y[15]}}, pos.y};
      end
      S_ZZ: begin
        mul_a = {{18{pos.z[15]}}, pos.z};
        mul_b = {{18{pos.z[15]}}, pos.z};
      end
      S_DD: begin
        mul_a = {19'b0, cfg.hip_off};
        mul_b = {19'b0, cfg.hip_off};
      end
      S_XX: begin
        mul_a = {{18{pos.x[15]}}, pos.x};
        mul_b = {{18{pos.x[15]}}, pos.x};
      end
      S_L1: begin
        mul_a = {19'b0, cfg.upper_len};
        mul_b = {19'b0, cfg.upper_len};
      end
      S_L2: begin
        mul_a = {19'b0, cfg.lower_len};
        mul_b = {19'b0, cfg.lower_len};
      end
      S_LL: begin
        mul_a = {19'b0, cfg.upper_len};
        mul_b = {19'b0, cfg.lower_len};
      end
      S_DEN2: begin
        mul_a = {2'b0, den};
        mul_b = {2'b0, den};
      end
      S_NUM2: begin
        mul_a = {1'b0, anum};
        mul_b = {1'b0, anum};
      end
      S_T1: begin
        mul_a = {19'b0, cfg.lower_len};
        mul_b = {3'b0, s};
      end
      S_T2: begin
        mul_a = {19'b0, cfg.upper_len};
        mul_b = {2'b0, den};
      end
      S_T3: begin
        mul_a = {19'b0, cfg.lower_len};
        mul_b = num;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Reach check: negative radius, zero link, or cosine beyond one.
  assign den_c  = {prod[30:0], 1'b0};
  assign anum_c = num[33] ? -num : num;
  assign fail   = r2[33] || (den_c == '0) || (anum_c > $signed({2'b0, den_c}));

  // Square root requests.
  assign sq_start = (state == S_RZ_GO) || (state == S_DIFF);
  assign sq_value = (state == S_RZ_GO) ? {{30{1'b0}}, r2} : acc_diff[lik_pkg::SQ_W-1:0];

  lik_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  // CORDIC operand selection by arctangent number.
  always_comb begin
    unique case (k)
      3'd0: begin
        cy = {{33{pos.z[15]}}, pos.z};
        cx = {{33{pos.y[15]}}, pos.y};
      end
      3'd1: begin
        cy = {33'b0, rz};
        cx = {34'b0, cfg.hip_off};
      end
      3'd2: begin
        cy = ay;
        cx = ax;
      end
      3'd3: begin
        cy = {33'b0, rz};
        cx = {{33{pos.x[15]}}, pos.x};
      end
      3'd4: begin
        cy = {18'b0, s};
        cx = {{15{num[33]}}, num};
      end
      default: begin
        cy = '0;
        cx = '0;
      end
    endcase
  end

  assign cd_start = (state == S_AT_GO);

  lik_cordic #(.ITERS(ITERS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cd_done),
    .angle (cd_angle)
  );

  // Solve sequence, last angles and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      last_hip   <= '0;
      last_thigh <= '0;
      last_knee  <= '0;
      k          <= '0;
    end else begin
      // A taken result frees the register unless a new word replaces it.
      if (out_pop && out_valid && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            pos   <= q_data;
            state <= S_YY;
          end
        end
        S_YY: state <= S_ZZ;
        S_ZZ: begin
          acc   <= prod[lik_pkg::ACC_W-1:0];
          state <= S_DD;
        end
        S_DD: begin
          acc   <= acc + prod[lik_pkg::ACC_W-1:0];
          state <= S_XX;
        end
        S_XX: begin
          r2    <= acc_diff[33:0];
          state <= S_L1;
        end
        S_L1: begin
          acc   <= prod[lik_pkg::ACC_W-1:0] + {{32{r2[33]}}, r2};
          state <= S_L2;
        end
        S_L2: begin
          acc   <= acc_diff;
          state <= S_LL;
        end
        S_LL: begin
          num   <= acc_diff[33:0];
          state <= S_CHK;
        end
        S_CHK: begin
          den  <= den_c;
          anum <= anum_c[32:0];
          if (fail) begin
            ok    <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_RZ_GO;
          end
        end
        S_RZ_GO: state <= S_RZ_WAIT;
        S_RZ_WAIT: begin
          if (sq_done) begin
            rz    <= sq_root[15:0];
            state <= S_DEN2;
          end
        end
        S_DEN2: state <= S_NUM2;
        S_NUM2: begin
          acc   <= prod[lik_pkg::ACC_W-1:0];
          state <= S_DIFF;
        end
        S_DIFF: state <= S_S_WAIT;
        S_S_WAIT: begin
          if (sq_done) begin
            s     <= sq_root[30:0];
            state <= S_T1;
          end
        end
        S_T1: state <= S_T2;
        S_T2: begin
          ay    <= prod[lik_pkg::ARG_W-1:0];
          state <= S_T3;
        end
        S_T3: begin
          acc   <= prod[lik_pkg::ACC_W-1:0];
          state <= S_T4;
        end
        S_T4: begin
          ax    <= acc[lik_pkg::ARG_W-1:0] + prod[lik_pkg::ARG_W-1:0];
          k     <= '0;
          state <= S_AT_GO;
        end
        S_AT_GO: state <= S_AT_WAIT;
        S_AT_WAIT: begin
          if (cd_done) begin
            at[k] <= cd_angle;
            k     <= k + 3'd1;
            state <= (k == 3'd4) ? S_FIN : S_AT_GO;
          end
        end
        S_FIN: begin
          last_hip   <= lik_pkg::sat16({at[0][16], at[0]} + {at[1][16], at[1]});
          last_thigh <= lik_pkg::sat16({at[2][16], at[2]} + {at[3][16], at[3]});
          last_knee  <= lik_pkg::sat16({at[4][16], at[4]});
          ok         <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_pop) begin
            out_valid         <= 1'b1;
            out_res.hip       <= last_hip;
            out_res.thigh     <= last_thigh;
            out_res.knee      <= last_knee;
            out_res.reachable <= ok;
            out_res.foot      <= pos;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics: three-joint leg solver.
// Keeps one foot position, moves or re-homes it per input word and solves
// hip, thigh and knee angles with integer square roots and CORDIC.
//
//   Channel  Handshake           Contents
//   input    push / full         op, front_leg, delta_x, delta_y, delta_z
//   result   pop / empty         angles, reachable, foot_x/y/z
//   config   psel/penable/pready seven registers at byte address 4*index
//
// A reachable word runs two square roots and five CORDIC arctangents in the
// solver, each arctangent made of operand scaling shifts and then ITERS CORDIC
// steps (ITERS is the CORDIC step count); an out-of-reach word leaves the
// solver after the reach check.
// A two-word queue lets the front take words while the solver works, and a
// waiting result stalls only the solver. Reset is synchronous, no clear pass.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic               front_leg,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [15:0] delta_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] hip_angle,
  output logic signed [15:0] thigh_angle,
  output logic signed [15:0] knee_angle,
  output logic               reachable,
  output logic signed [15:0] foot_x,
  output logic signed [15:0] foot_y,
  output logic signed [15:0] foot_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ITERS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

  lik_pkg::cfg_t cfg;
  lik_pkg::pos_t q_wr_data, q_rd_data;
  lik_pkg::res_t res;
  logic          q_push, q_pop, q_full, q_empty;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        lik_pkg::REG_UPPER_LEN:   cfg.upper_len    <= pwdata[14:0];
        lik_pkg::REG_LOWER_LEN:   cfg.lower_len    <= pwdata[14:0];
        lik_pkg::REG_HIP_OFFSET:  cfg.hip_off      <= pwdata[14:0];
        lik_pkg::REG_HOME_XFRONT: cfg.home_x_front <= pwdata[15:0];
        lik_pkg::REG_HOME_XBACK:  cfg.home_x_back  <= pwdata[15:0];
        lik_pkg::REG_HOME_Y:      cfg.home_y       <= pwdata[15:0];
        lik_pkg::REG_HOME_Z:      cfg.home_z       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_idx)
      lik_pkg::REG_UPPER_LEN:   prdata = {17'b0, cfg.upper_len};
      lik_pkg::REG_LOWER_LEN:   prdata = {17'b0, cfg.lower_len};
      lik_pkg::REG_HIP_OFFSET:  prdata = {17'b0, cfg.hip_off};
      lik_pkg::REG_HOME_XFRONT: prdata = {{16{cfg.home_x_front[15]}}, cfg.home_x_front};
      lik_pkg::REG_HOME_XBACK:  prdata = {{16{cfg.home_x_back[15]}}, cfg.home_x_back};
      lik_pkg::REG_HOME_Y:      prdata = {{16{cfg.home_y[15]}}, cfg.home_y};
      lik_pkg::REG_HOME_Z:      prdata = {{16{cfg.home_z[15]}}, cfg.home_z};
      default:                  prdata = '0;
    endcase
  end

  assign full = q_full;

  lik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .op        (op),
    .front_leg (front_leg),
    .delta_x   (delta_x),
    .delta_y   (delta_y),
    .delta_z   (delta_z),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  lik_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  lik_solver #(.ITERS(ITERS)) u_solver (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_res   (res)
  );

  assign hip_angle   = res.hip;
  assign thigh_angle = res.thigh;
  assign knee_angle  = res.knee;
  assign reachable   = res.reachable;
  assign foot_x      = res.foot.x;
  assign foot_y      = res.foot.y;
  assign foot_z      = res.foot.z;

endmodule

>>> sv/lik_checker.sv
// ----------------------------------------------------------------------------
// lik_checker: port-level checks of the leg solver.
// Watches reset behavior of the input queue and the result register, and result stability under stall.
// ----------------------------------------------------------------------------
module lik_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] hip_angle,
  input logic signed [15:0] knee_angle,
  input logic               reachable,
  input logic signed [15:0] foot_x
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // Reset leaves room for input words.
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input full right after reset");

  // A result that is not taken stays and keeps its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(hip_angle) && $stable(knee_angle)
                          && $stable(reachable) && $stable(foot_x)))
    else $error("waiting result changed or vanished");

endmodule

bind leg_inverse_kinematics lik_checker u_lik_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .hip_angle   (hip_angle),
  .knee_angle  (knee_angle),
  .reachable   (reachable),
  .foot_x      (foot_x)
);
